@@ hw/rtl/wsdm_pkg.sv @@
// Package for the wheel speed and distance meter: field widths, request codes,
// register indexes, reset values and scaling constants.
// No dependencies.
`default_nettype none

package wsdm_pkg;

    // Field and register widths.
    localparam int REQ_W      = 2;
    localparam int TIME_W     = 32;
    localparam int SPEED_W    = 16;
    localparam int DIST_W     = 44;
    localparam int CIRC_W     = 12;
    localparam int MINREV_W   = 20;
    localparam int WINDOW_W   = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Speed arithmetic widths: circumference times scale fits 31 bits, and
    // the full numerator circumference * revolutions * scale fits 63 bits.
    localparam int SCALE_W = 19;
    localparam int K_W     = 31;
    localparam int NUM_W   = 63;

    typedef logic [TIME_W-1:0] t_time;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PULSE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CIRC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MINREV = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;

    // Register reset values.
    localparam logic [CIRC_W-1:0]   CIRC_RESET   = 12'd2090;
    localparam logic [MINREV_W-1:0] MINREV_RESET = 20'd94050;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 24'd500000;

    // Hundredths of km/h per mm/us, and the saturation value of the speed.
    localparam logic [SCALE_W-1:0] CENTI_KMH_SCALE = 19'd360000;
    localparam logic [SPEED_W-1:0] SPEED_MAX       = 16'hFFFF;

endpackage

`default_nettype wire

@@ hw/rtl/wheel_speed_distance_meter.sv @@
// Top level of the wheel speed and distance meter: event sequencer, bit-serial
// speed multiplier and divider, bit-serial distance multiplier.
// Depends on wsdm_pkg.
`default_nettype none

// Each input word is a timestamped event (wheel pulse, speed query or distance
// clear) and yields exactly one output word carrying the current speed in
// 0.01 km/h and the distance since the last clear in millimetres. Words are
// handled one at a time. An event that needs no speed recomputation passes
// from acceptance to the output register through evaluation, setup, the
// bit-serial circumference multiply for distance and the output load. A wheel
// pulse that closes a speed window, or a speed query after a stale window,
// adds the speed computation: the shift-add multiplier, which steps through
// the significant bits of the revolution count until it finds the multiplier
// empty, one range check, restoring division over the sixteen quotient bits
// unless the result saturates, and applying the result. The block takes the
// next input word as soon as the sequencer is back in idle, even while the
// previous output word still waits to be taken. Configuration writes are
// always accepted; they are expected only while the block is idle, and the
// registers are read live.

module wheel_speed_distance_meter (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [wsdm_pkg::REQ_W-1:0]          i_req_type,
    input  wire logic [wsdm_pkg::TIME_W-1:0]         i_time_us,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [wsdm_pkg::SPEED_W-1:0]             o_speed_centi_kmh,
    output logic [wsdm_pkg::DIST_W-1:0]              o_distance_mm,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [wsdm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [wsdm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import wsdm_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_APPLY = 3'd5;
    localparam logic [2:0] S_DSET  = 3'd6;
    localparam logic [2:0] S_DIST  = 3'd7;

    // The division runs over the low quotient bits, the distance multiply over
    // the circumference bits; one counter serves both.
    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(SPEED_W - 1);
    localparam logic [CNT_W-1:0] DMUL_LAST = CNT_W'(CIRC_W - 1);
    localparam int HI_W = NUM_W - SPEED_W;

    logic [2:0]           r_state;
    logic                 r_out_valid;
    logic                 r_out_load;

    // Configuration registers.
    logic [CIRC_W-1:0]    r_circ;
    logic [MINREV_W-1:0]  r_min_rev;
    logic [WINDOW_W-1:0]  r_window;

    // Meter state.
    t_time                r_last_accept;
    t_time                r_total_revs;
    t_time                r_win_start_time;
    t_time                r_win_start_revs;
    t_time                r_last_update;
    t_time                r_last_reject;
    t_time                r_base_revs;
    logic [SPEED_W-1:0]   r_speed;

    // Datapath registers.
    logic [REQ_W-1:0]     r_req;
    t_time                r_now;
    logic                 r_is_query;
    logic [CNT_W-1:0]     r_cnt;
    logic [NUM_W-1:0]     r_mcand;
    logic [NUM_W-1:0]     r_acc;
    t_time                r_mplier;
    t_time                r_dt;
    t_time                r_rem;
    logic [SPEED_W-1:0]   r_lo;
    logic [SPEED_W-1:0]   r_quot;
    logic [DIST_W-1:0]    r_dmcand;
    logic [DIST_W-1:0]    r_dacc;
    logic [CIRC_W-1:0]    r_dmplier;
    logic [SPEED_W-1:0]   r_out_speed;
    logic [DIST_W-1:0]    r_out_dist;

    // Event evaluation terms; all time differences wrap modulo 2^32.
    t_time                accept_gap;
    t_time                window_gap;
    t_time                update_gap;
    t_time                reject_gap;
    t_time                revs_inc;
    logic                 pulse_ok;
    logic                 window_passed;
    logic                 update_stale;
    logic                 in_accept;
    logic                 out_free;
    logic [TIME_W+1:0]    trial;

    assign accept_gap    = r_now - r_last_accept;
    assign window_gap    = r_now - r_win_start_time;
    assign update_gap    = r_now - r_last_update;
    assign reject_gap    = r_now - r_last_reject;
    assign revs_inc      = r_total_revs + 32'd1;
    assign pulse_ok      = accept_gap > {{(TIME_W-MINREV_W){1'b0}}, r_min_rev};
    assign window_passed = window_gap > {{(TIME_W-WINDOW_W){1'b0}}, r_window};
    assign update_stale  = update_gap > {{(TIME_W-WINDOW_W){1'b0}}, r_window};

    // One restoring division step: bring down the next numerator bit and try
    // to subtract the divisor. The top bit of the difference is the borrow.
    assign trial = {1'b0, r_rem, r_lo[SPEED_W-1]} - {2'b00, r_dt};

    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_speed_centi_kmh = r_out_speed;
    assign o_distance_mm     = r_out_dist;

    // Control, configuration and meter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_out_valid      <= 1'b0;
            r_out_load       <= 1'b0;
            r_circ           <= CIRC_RESET;
            r_min_rev        <= MINREV_RESET;
            r_window         <= WINDOW_RESET;
            r_last_accept    <= '0;
            r_total_revs     <= '0;
            r_win_start_time <= '0;
            r_win_start_revs <= '0;
            r_last_update    <= '0;
            r_last_reject    <= '0;
            r_base_revs      <= '0;
            r_speed          <= '0;
        end else begin
            r_out_load <= (r_state == S_DIST) && (r_cnt == '0) && out_free;
            if (r_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_CIRC:   r_circ    <= i_cfg_data[CIRC_W-1:0];
                    REG_MINREV: r_min_rev <= i_cfg_data[MINREV_W-1:0];
                    REG_WINDOW: r_window  <= i_cfg_data[WINDOW_W-1:0];
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    case (r_req)
                        REQ_PULSE: begin
                            if (pulse_ok) begin
                                r_total_revs  <= revs_inc;
                                r_last_accept <= r_now;
                                if (window_passed) begin
                                    r_win_start_time <= r_now;
                                    r_last_update    <= r_now;
                                    r_win_start_revs <= revs_inc;
                                    r_state          <= S_MUL;
                                end else begin
                                    r_state <= S_DSET;
                                end
                            end else begin
                                r_last_reject <= r_now;
                                r_state       <= S_DSET;
                            end
                        end
                        REQ_QUERY: begin
                            if (update_stale) begin
                                r_state <= S_MUL;
                            end else begin
                                r_state <= S_DSET;
                            end
                        end
                        REQ_CLEAR: begin
                            r_base_revs <= r_total_revs;
                            r_state     <= S_DSET;
                        end
                        default: begin
                            r_state <= S_DSET;
                        end
                    endcase
                end
                S_MUL: begin
                    if (r_mplier == '0) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    // A zero divisor always lands in the saturating branch.
                    if (r_acc[NUM_W-1:SPEED_W] >= {{(HI_W-TIME_W){1'b0}}, r_dt}) begin
                        r_state <= S_APPLY;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    // A pulse takes the new speed; a decay query only lowers it.
                    if (!r_is_query) begin
                        r_speed <= r_quot;
                    end else if (r_quot < r_speed) begin
                        r_speed       <= r_quot;
                        r_last_update <= r_now;
                    end
                    r_state <= S_DSET;
                end
                S_DSET: begin
                    r_state <= S_DIST;
                end
                S_DIST: begin
                    if (r_cnt == '0 && out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath: serial multipliers, divider and output word.
    always_ff @(posedge i_clk) begin
        if (r_out_load) begin
            r_out_speed <= r_speed;
            r_out_dist  <= r_dacc;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_req <= i_req_type;
                    r_now <= i_time_us;
                end
            end
            S_EVAL: begin
                r_mcand    <= {{(NUM_W-K_W){1'b0}}, K_W'(r_circ) * K_W'(CENTI_KMH_SCALE)};
                r_acc      <= '0;
                r_is_query <= (r_req == REQ_QUERY);
                if (r_req == REQ_PULSE) begin
                    r_mplier <= revs_inc - r_win_start_revs;
                    r_dt     <= window_gap;
                end else if (r_total_revs == r_win_start_revs) begin
                    // No revolutions since the window start: bound by one.
                    r_mplier <= 32'd1;
                    r_dt     <= window_gap;
                end else begin
                    r_mplier <= r_total_revs - r_win_start_revs;
                    r_dt     <= reject_gap;
                end
            end
            S_MUL: begin
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= {r_mcand[NUM_W-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[TIME_W-1:1]};
            end
            S_CHK: begin
                // High part below the divisor means the quotient fits the field.
                r_quot <= SPEED_MAX;
                r_rem  <= r_acc[SPEED_W+TIME_W-1:SPEED_W];
                r_lo   <= r_acc[SPEED_W-1:0];
                r_cnt  <= DIV_LAST;
            end
            S_DIV: begin
                if (!trial[TIME_W+1]) begin
                    r_rem <= trial[TIME_W-1:0];
                end else begin
                    r_rem <= {r_rem[TIME_W-2:0], r_lo[SPEED_W-1]};
                end
                r_quot <= {r_quot[SPEED_W-2:0], !trial[TIME_W+1]};
                r_lo   <= {r_lo[SPEED_W-2:0], 1'b0};
                r_cnt  <= r_cnt - CNT_W'(1);
            end
            S_APPLY: begin
            end
            S_DSET: begin
                r_dmcand  <= {{(DIST_W-TIME_W){1'b0}}, r_total_revs - r_base_revs};
                r_dmplier <= r_circ;
                r_dacc    <= '0;
                r_cnt     <= DMUL_LAST;
            end
            S_DIST: begin
                // The counter parks at zero while the output word is occupied;
                // the multiplier is then empty and the sum holds.
                if (r_dmplier[0]) begin
                    r_dacc <= r_dacc + r_dmcand;
                end
                r_dmcand  <= {r_dmcand[DIST_W-2:0], 1'b0};
                r_dmplier <= {1'b0, r_dmplier[CIRC_W-1:1]};
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire
